FILE: hdl/sal_pkg.sv
// Shared constants, types and the arctangent table for the segment angle and length block.
package sal_pkg;

   localparam int COORD_BITS      = 16;
   localparam int COORD_FRAC_BITS = 4;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int CORDIC_STAGES   = 18;

   localparam int ZSCALE_BITS = 24;
   localparam int GUARD_BITS  = 16;
   localparam int TABLE_LEN   = 30;

   localparam int LEN_W      = COORD_BITS + 1;
   localparam int ANGLE_W    = ANGLE_FRAC_BITS + 9;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS + 1;
   localparam int SQRT_STEPS = COORD_BITS + 1;
   localparam int XY_W       = DIFF_W + GUARD_BITS + 3;
   localparam int Z_W        = ZSCALE_BITS + 10;
   localparam int CELL_COUNT = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int SH_W       = $clog2(SQ_W);
   localparam int ROUND_SH   = ZSCALE_BITS - ANGLE_FRAC_BITS;

   localparam longint HALF_TURN = longint'(180) << ZSCALE_BITS;
   localparam int     ANG_LIM   = 180 << ANGLE_FRAC_BITS;
   localparam int     ANG_RIGHT = 90 << ANGLE_FRAC_BITS;

   localparam logic signed [ANGLE_W-1:0] ANG_RIGHT_POS = ANGLE_W'(ANG_RIGHT);
   localparam logic signed [ANGLE_W-1:0] ANG_RIGHT_NEG = ANGLE_W'(-ANG_RIGHT);
   localparam logic signed [ANGLE_W-1:0] ANG_LIM_POS   = ANGLE_W'(ANG_LIM);
   localparam logic signed [ANGLE_W-1:0] ANG_LIM_NEG   = ANGLE_W'(-ANG_LIM);
   localparam logic [LEN_W-1:0]          PIX_ONE_LEN   = LEN_W'(1 << COORD_FRAC_BITS);

   // atan(2^-i) in degrees, 24 fraction bits
   localparam int ATAN_TAB [TABLE_LEN] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
      115, 57, 29, 14, 7, 4, 2
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] first_x;
      logic [COORD_BITS-1:0] first_y;
      logic [COORD_BITS-1:0] second_x;
      logic [COORD_BITS-1:0] second_y;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]          seg_length;
      logic signed [ANGLE_W-1:0] angle_deg;
      logic                      is_vertical;
   } rsp_type;

   // Data handed from cell to cell: rotation vector, angle sum, root, remainder and the vertical flags
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [SQ_W-1:0]        root;
      logic [SQ_W-1:0]        rem;
      logic                   vert;
      logic                   vert_down;
   } cell_type;

endpackage

FILE: hdl/sal_front.sv
// Front end: coordinate differences, squares, sum of squares and the quadrant pre-rotation.
module sal_front import sal_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  req,
   output logic     out_valid,
   output cell_type out_cell
);

   localparam logic signed [DIFF_W-1:0] PIX_ONE = DIFF_W'(1 << COORD_FRAC_BITS);

   logic                        a_valid_ff, b_valid_ff, c_valid_ff;
   logic signed [DIFF_W-1:0]    dx_ff, dy_ff, dx_in, dy_in;
   logic signed [2*DIFF_W-1:0]  prod_x, prod_y;
   logic [2*COORD_BITS-1:0]     sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic signed [XY_W-1:0]      dxg, dyg;
   cell_type                    b_ff, b_in, c_ff, c_in;

   always_comb begin
      dx_in = signed'({1'b0, req.second_x}) - signed'({1'b0, req.first_x});
      dy_in = signed'({1'b0, req.second_y}) - signed'({1'b0, req.first_y});
   end

   always_comb begin
      prod_x = dx_ff * dx_ff;
      prod_y = dy_ff * dy_ff;
      sqx_in = prod_x[2*COORD_BITS-1:0];
      sqy_in = prod_y[2*COORD_BITS-1:0];
      dxg    = XY_W'(dx_ff) <<< GUARD_BITS;
      dyg    = XY_W'(dy_ff) <<< GUARD_BITS;
      b_in           = '0;
      b_in.vert      = (dx_ff > -PIX_ONE) && (dx_ff < PIX_ONE);
      b_in.vert_down = dy_ff > 0;
      // fold the left half-plane onto the right, starting from a half turn
      if (dx_ff < 0) begin
         b_in.x = -dxg;
         b_in.y = dyg;
         b_in.z = (dy_ff <= 0) ? Z_W'(HALF_TURN) : -Z_W'(HALF_TURN);
      end else begin
         b_in.x = dxg;
         b_in.y = -dyg;
         b_in.z = '0;
      end
   end

   always_comb begin
      c_in      = b_ff;
      c_in.root = '0;
      c_in.rem  = SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= take;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= sqx_in;
      sqy_ff <= sqy_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
   end

   assign out_valid = c_valid_ff;
   assign out_cell  = c_ff;

endmodule

FILE: hdl/sal_cell.sv
// One cell of the chain: a CORDIC vectoring step and, where idx is below SQRT_STEPS, one digit of the square root.
module sal_cell import sal_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] idx,
   input  logic             in_valid,
   input  cell_type         in_cell,
   output logic             out_valid,
   output cell_type         out_cell
);

   logic                   valid_ff;
   cell_type               cell_ff, cell_in;
   logic                   rot_on, sq_on;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  at;
   logic [SH_W-1:0]        bit_sh;
   logic [SQ_W-1:0]        bit_v;
   logic [SQ_W:0]          trial;

   always_comb begin
      rot_on = int'(idx) < CORDIC_STAGES;
      sq_on  = int'(idx) < SQRT_STEPS;
      xs     = in_cell.x >>> idx;
      ys     = in_cell.y >>> idx;
      at     = rot_on ? Z_W'(ATAN_TAB[idx]) : '0;
      bit_sh = sq_on ? SH_W'(2 * (SQRT_STEPS - 1 - int'(idx))) : '0;
      bit_v  = SQ_W'(1) << bit_sh;
      trial  = {1'b0, in_cell.root} + {1'b0, bit_v};
      cell_in = in_cell;
      if (rot_on) begin
         if (!in_cell.y[XY_W-1]) begin
            cell_in.x = in_cell.x + ys;
            cell_in.y = in_cell.y - xs;
            cell_in.z = in_cell.z + at;
         end else begin
            cell_in.x = in_cell.x - ys;
            cell_in.y = in_cell.y + xs;
            cell_in.z = in_cell.z - at;
         end
      end
      if (sq_on) begin
         if ({1'b0, in_cell.rem} >= trial) begin
            cell_in.rem  = in_cell.rem - trial[SQ_W-1:0];
            cell_in.root = (in_cell.root >> 1) + bit_v;
         end else begin
            cell_in.root = in_cell.root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign out_valid = valid_ff;
   assign out_cell  = cell_ff;

endmodule

FILE: hdl/segment_angle_and_length.sv
// Top level: front end, chain of CORDIC and root cells, rounding and output register.
//
//   channel   ports                          direction   payload
//   request   start, busy, req_data          in          req_type (two points)
//   result    rsp_valid, rsp_data            out         rsp_type (length, angle, flag)
//
// A request is taken in every cycle; busy stays low.
// The pipeline has three front stages for the differences, squares and sum,
// one cell per CORDIC step or root digit, and one output stage.
// Reset clears the valid bits along the pipeline; data registers are not reset.
// rsp_valid is a one-cycle strobe and the receiver cannot stall it.
module segment_angle_and_length import sal_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AF_W = Z_W + 1 - ROUND_SH;
   localparam logic signed [AF_W-1:0] LIM_HI = AF_W'(ANG_LIM);
   localparam logic signed [AF_W-1:0] LIM_LO = AF_W'(-ANG_LIM);

   logic                   chain_valid [CELL_COUNT+1];
   cell_type               chain_cell  [CELL_COUNT+1];
   cell_type               last;
   logic signed [Z_W:0]    zr;
   logic signed [AF_W-1:0] ang_full, ang_sat;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   assign busy = 1'b0;

   sal_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (start && !busy),
      .req       (req_data),
      .out_valid (chain_valid[0]),
      .out_cell  (chain_cell[0])
   );

   for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
      sal_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .idx       (IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_cell   (chain_cell[g]),
         .out_valid (chain_valid[g+1]),
         .out_cell  (chain_cell[g+1])
      );
   end

   always_comb begin
      last     = chain_cell[CELL_COUNT];
      // round to nearest, ties upward
      zr       = (Z_W+1)'(last.z) + (Z_W+1)'(1 << (ROUND_SH - 1));
      ang_full = signed'(zr[Z_W:ROUND_SH]);
      if (ang_full > LIM_HI) begin
         ang_sat = LIM_HI;
      end else if (ang_full < LIM_LO) begin
         ang_sat = LIM_LO;
      end else begin
         ang_sat = ang_full;
      end
      rsp_in.seg_length  = last.root[LEN_W-1:0] + LEN_W'(last.rem > last.root);
      rsp_in.is_vertical = last.vert;
      if (last.vert) begin
         rsp_in.angle_deg = last.vert_down ? ANG_RIGHT_NEG : ANG_RIGHT_POS;
      end else begin
         rsp_in.angle_deg = signed'(ang_sat[ANGLE_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain_valid[CELL_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_vert_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_vertical |->
         (rsp_data.angle_deg == ANG_RIGHT_POS || rsp_data.angle_deg == ANG_RIGHT_NEG))
      else $error("vertical segment without a right angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_vertical |->
         (rsp_data.angle_deg <= ANG_LIM_POS && rsp_data.angle_deg >= ANG_LIM_NEG))
      else $error("angle beyond a half turn");

   a_zero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.seg_length == '0 |-> rsp_data.is_vertical)
      else $error("coincident points not flagged vertical");

   a_min_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_vertical |-> rsp_data.seg_length >= PIX_ONE_LEN)
      else $error("non-vertical segment shorter than one pixel");

endmodule

FILE: dv/tb_segment_angle_and_length.sv
// Testbench for segment_angle_and_length: directed and random point pairs checked against a predictor.
`timescale 1ns / 100ps

module tb_segment_angle_and_length;
   import sal_pkg::*;

   typedef logic [COORD_BITS-1:0] coord_type;

   localparam int  RANDOM_REQUESTS = 900;
   localparam int  CALM_TAIL       = 100;
   localparam int  SETTLE_CYCLES   = 40;
   localparam int  WATCHDOG_LIMIT  = 2000;
   localparam int  Z_FRAC          = 24;
   localparam int  XY_GUARD        = 16;
   localparam int  ATAN_STEPS      = 30;
   localparam int  ROUND_SHIFT     = Z_FRAC - ANGLE_FRAC_BITS;
   localparam longint ANGLE_MAX    = longint'(180) << ANGLE_FRAC_BITS;
   localparam longint ANGLE_RIGHT  = longint'(90) << ANGLE_FRAC_BITS;

   // atan(2^-i) in degrees with 24 fraction bits
   localparam longint ATAN_DEG [ATAN_STEPS] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
      115, 57, 29, 14, 7, 4, 2
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_segments[$];

   logic req_taken = 1'b0;
   int   idle_left = 0;
   int   n_queued = 0;
   int   n_taken = 0;
   int   n_results = 0;
   int   n_vertical = 0;
   int   n_errors = 0;
   int   stall_cycles = 0;

   segment_angle_and_length i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Length by rounded integer square root, angle by a vectoring CORDIC in degrees
   function automatic rsp_type predict_segment(req_type r);
      longint dx, dy, adx, x, y, z, xs, ys, ang;
      longint unsigned sq, root, probe, rem;
      rsp_type res;
      dx  = longint'(r.second_x) - longint'(r.first_x);
      dy  = longint'(r.second_y) - longint'(r.first_y);
      adx = (dx < 0) ? -dx : dx;
      sq  = longint'(dx * dx) + longint'(dy * dy);
      root  = 0;
      rem   = sq;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (sq > root * root + root) root = root + 1;

      if (adx < (longint'(1) << COORD_FRAC_BITS)) begin
         res.is_vertical = 1'b1;
         ang = (r.second_y > r.first_y) ? -ANGLE_RIGHT : ANGLE_RIGHT;
      end else begin
         res.is_vertical = 1'b0;
         x = dx * (longint'(1) << XY_GUARD);
         y = -dy * (longint'(1) << XY_GUARD);
         z = 0;
         // fold the left half-plane onto the right one
         if (x < 0) begin
            z = (y >= 0) ? (longint'(180) << Z_FRAC) : -(longint'(180) << Z_FRAC);
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STAGES && i < ATAN_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_DEG[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_DEG[i];
            end
         end
         ang = (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         if (ang > ANGLE_MAX) ang = ANGLE_MAX;
         if (ang < -ANGLE_MAX) ang = -ANGLE_MAX;
      end
      res.seg_length = root[LEN_W-1:0];
      res.angle_deg  = ang[ANGLE_W-1:0];
      return res;
   endfunction

   function automatic coord_type offset_coord(coord_type base, int span);
      int off;
      off = int'($urandom_range(0, 2 * span)) - span;
      return coord_type'(int'(base) + off);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic add_request(coord_type x1, coord_type y1, coord_type x2, coord_type y2);
      req_type r;
      r.first_x  = x1;
      r.first_y  = y1;
      r.second_x = x2;
      r.second_y = y2;
      pending_requests.insert(pending_requests.size(), r);
      n_queued++;
   endtask

   // Driver: present one request at a time, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !req_taken) begin
         // hold
      end else if (idle_left > 0) begin
         start <= 1'b0;
         idle_left--;
      end else if (pending_requests.size() > 0) begin
         if (pending_requests.size() > CALM_TAIL && (pending_requests.size() / 100) % 3 != 0 &&
             $urandom_range(0, 9) == 0) begin
            idle_left = $urandom_range(1, 15) - 1;
            start <= 1'b0;
         end else begin
            req_data <= pending_requests.pop_front();
            start    <= 1'b1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predict on each taken request, compare each result strobe
   always @(posedge clock) begin
      rsp_type want;
      logic    progress;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         progress = 1'b0;
         req_taken <= start && busy === 1'b0;
         if (start && busy === 1'b0) begin
            expected_segments.insert(expected_segments.size(), predict_segment(req_data));
            n_taken++;
            progress = 1'b1;
         end
         if (rsp_valid === 1'b1) begin
            progress = 1'b1;
            n_results++;
            if (expected_segments.size() == 0) begin
               $display("%0t: unexpected result, length %0d angle %0d vertical %0b",
                        $time, rsp_data.seg_length, rsp_data.angle_deg, rsp_data.is_vertical);
               n_errors++;
            end else begin
               want = expected_segments.pop_front();
               if (want.is_vertical) n_vertical++;
               if (rsp_data.seg_length !== want.seg_length) begin
                  $display("%0t: seg_length expected %0d actual %0d",
                           $time, want.seg_length, rsp_data.seg_length);
                  n_errors++;
               end
               if (rsp_data.angle_deg !== want.angle_deg) begin
                  $display("%0t: angle_deg expected %0d actual %0d",
                           $time, want.angle_deg, rsp_data.angle_deg);
                  n_errors++;
               end
               if (rsp_data.is_vertical !== want.is_vertical) begin
                  $display("%0t: is_vertical expected %0b actual %0b",
                           $time, want.is_vertical, rsp_data.is_vertical);
                  n_errors++;
               end
            end
         end
         if (progress) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      coord_type x1, y1, x2, y2;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      add_request(16'd0, 16'd0, 16'd0, 16'd0);
      add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_request(16'd0, 16'd0, 16'hFFFF, 16'd0);
      add_request(16'hFFFF, 16'd0, 16'd0, 16'd0);
      add_request(16'd0, 16'd0, 16'd0, 16'hFFFF);
      add_request(16'd0, 16'hFFFF, 16'd0, 16'd0);
      add_request(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      add_request(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      add_request(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      add_request(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
      add_request(16'd100, 16'd200, 16'd115, 16'd900);
      add_request(16'd115, 16'd900, 16'd100, 16'd200);
      add_request(16'd100, 16'd200, 16'd116, 16'd900);
      add_request(16'd116, 16'd900, 16'd100, 16'd200);
      add_request(16'd1000, 16'd500, 16'd1015, 16'd500);
      add_request(16'd5000, 16'd300, 16'd100, 16'd300);
      add_request(16'd5000, 16'd300, 16'd100, 16'd301);
      add_request(16'd5000, 16'd301, 16'd100, 16'd300);
      add_request(16'd3000, 16'd3000, 16'd3160, 16'd2840);
      add_request(16'd0, 16'd0, 16'd1, 16'd0);
      add_request(16'd32768, 16'd32768, 16'd32767, 16'd32769);
      add_request(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFE);

      // starve the block until the pipeline has drained
      while (n_taken != n_queued || expected_segments.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         x1 = coord_type'($urandom);
         y1 = coord_type'($urandom);
         x2 = coord_type'($urandom);
         y2 = coord_type'($urandom);
         case ($urandom_range(0, 9))
            3, 4: begin
               x2 = offset_coord(x1, 40);
               y2 = offset_coord(y1, 40);
            end
            5: begin
               x2 = offset_coord(x1, 20);
               y2 = offset_coord(y1, 4000);
            end
            6: begin
               x2 = offset_coord(x1, 30000);
               y2 = offset_coord(y1, 2);
            end
            7: begin
               x1 = edge_coord();
               y1 = edge_coord();
               x2 = edge_coord();
               y2 = edge_coord();
            end
            8: begin
               // straddle the one-pixel boundary on dx
               x2 = coord_type'(int'(x1) + ($urandom_range(0, 1) ? 1 : -1) *
                                int'($urandom_range(15, 16)));
               y2 = offset_coord(y1, 3000);
            end
            9: begin
               if ($urandom_range(0, 1)) begin
                  x2 = x1;
                  y2 = y1;
               end else begin
                  y2 = y1;
                  x2 = offset_coord(x1, 20000);
               end
            end
            default: ;
         endcase
         add_request(x1, y1, x2, y2);
      end

      while (n_taken != n_queued || expected_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d point pairs (%0d results, %0d near-vertical)",
               n_taken, n_results, n_vertical);
      $display("Directed extremes, pixel boundary, leftward and coincident cases, then random");
      if (n_errors == 0 && expected_segments.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results outstanding", n_errors, expected_segments.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: segment_angle_and_length.f
hdl/sal_pkg.sv
hdl/sal_front.sv
hdl/sal_cell.sv
hdl/segment_angle_and_length.sv
dv/tb_segment_angle_and_length.sv
